// ----- sv/sap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

	// result kinds carried on the output channel
	typedef enum logic [1:0] {
		K_KEY  = 2'd0,
		K_VAL  = 2'd1,
		K_ERR  = 2'd2,
		K_DONE = 2'd3
	} kind_t;

	// two-byte tag codes, first byte in the low half
	localparam logic [15:0] TAG_ARRAY  = 16'h3a61;
	localparam logic [15:0] TAG_STRING = 16'h3a73;
	localparam logic [15:0] TAG_DOUBLE = 16'h3a64;
	localparam logic [15:0] TAG_INT    = 16'h3a69;
	localparam logic [15:0] TAG_NULL   = 16'h3b4e;

	// characters the parser looks for
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7b;

	// one result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       field_end;
		logic       empty_field;
	} out_item_t;

endpackage

`default_nettype wire

// ----- sv/sap_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sap_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- sv/sap_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sap_out_if;
	logic          valid;
	logic          ready;
	sap_pkg::kind_t kind;
	logic [7:0]    out_byte;
	logic          field_end;
	logic          empty_field;

	modport source (output valid, output kind, output out_byte, output field_end,
		output empty_field, input ready);
	modport sink (input valid, input kind, input out_byte, input field_end,
		input empty_field, output ready);
endinterface

`default_nettype wire

// ----- sv/serialized_array_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Request
// in_ch     in   in_byte[7:0], in_last                     one text byte
// out_ch    out  kind[1:0], out_byte[7:0], field_end,      one key/value byte,
//                empty_field                               error or completion
//
// One byte is accepted per clock; the parse step runs in the cycle of acceptance
// and its 0 to 2 results enter a four-entry result queue.
// in_ch.ready is high while the queue has room for two results, so the rate is one
// byte per cycle unless out_ch stalls or bytes that yield two results pile up.
// A result leaves the queue no earlier than the cycle after its byte was taken.
// arst_n clears the parser state and empties the queue; no clearing pass is needed.
module serialized_array_parser #(
	parameter int LEN_BITS   = 20,
	parameter int COUNT_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	sap_in_if.sink     in_ch,
	sap_out_if.source  out_ch
);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef enum logic [3:0] {
		PH_TAG0  = 4'd0,
		PH_TAG1  = 4'd1,
		PH_ADIG  = 4'd2,
		PH_ASEEK = 4'd3,
		PH_SDIG  = 4'd4,
		PH_SSEEK = 4'd5,
		PH_SBODY = 4'd6,
		PH_NUM   = 4'd7,
		PH_DONE  = 4'd8
	} phase_t;

	// parser state
	phase_t                phase_q, phase_d;
	logic [7:0]            tag_q, tag_d;
	logic [COUNT_BITS-1:0] pairs_q, pairs_d;
	logic                  expect_q, expect_d;
	logic [LEN_BITS-1:0]   bytes_q, bytes_d;
	logic [1:0]            skip_q, skip_d;

	// result queue
	sap_pkg::out_item_t fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic               acc, pop;
	logic               main_v, last_v, finish, seek_a, seek_s;
	sap_pkg::out_item_t main_r, last_r, res0, res1;
	logic [1:0]         n_push;
	sap_pkg::kind_t     kind_c;
	logic               digit;
	logic [3:0]         digit_val;
	logic [15:0]        code;
	logic [COUNT_BITS+3:0] pairs_w, pairs_acc;
	logic [LEN_BITS+3:0]   bytes_w, bytes_acc;
	logic [LEN_BITS-1:0]   bytes_dec;

	assign acc = in_ch.valid && in_ch.ready;
	assign pop = out_ch.valid && out_ch.ready;
	assign in_ch.ready = count_q <= CNT_W'(FIFO_DEPTH - 2);

	// decode helpers
	assign digit     = (in_ch.in_byte >= sap_pkg::CH_ZERO) && (in_ch.in_byte <= sap_pkg::CH_NINE);
	assign digit_val = 4'(in_ch.in_byte - sap_pkg::CH_ZERO);
	assign kind_c    = expect_q ? sap_pkg::K_VAL : sap_pkg::K_KEY;
	assign code      = {in_ch.in_byte, tag_q};

	// accumulate one decimal digit: acc*10 = acc*8 + acc*2
	assign pairs_w   = {4'd0, pairs_q};
	assign pairs_acc = (pairs_w << 3) + (pairs_w << 1) + {{COUNT_BITS{1'b0}}, digit_val};
	assign bytes_w   = {4'd0, bytes_q};
	assign bytes_acc = (bytes_w << 3) + (bytes_w << 1) + {{LEN_BITS{1'b0}}, digit_val};
	assign bytes_dec = bytes_q - LEN_BITS'(1);

	// one parse step on the offered byte
	always_comb begin
		phase_d  = phase_q;
		tag_d    = tag_q;
		pairs_d  = pairs_q;
		expect_d = expect_q;
		bytes_d  = bytes_q;
		skip_d   = skip_q;
		main_v   = 1'b0;
		main_r   = '{kind: sap_pkg::K_KEY, out_byte: 8'd0, field_end: 1'b0, empty_field: 1'b0};
		last_v   = 1'b0;
		last_r   = '{kind: sap_pkg::K_KEY, out_byte: 8'd0, field_end: 1'b0, empty_field: 1'b0};
		finish   = 1'b0;
		seek_a   = 1'b0;
		seek_s   = 1'b0;

		case (phase_q)
			PH_TAG0: begin
				if (skip_q != 2'd0) begin
					skip_d = skip_q - 2'd1;
				end else if (in_ch.in_byte == sap_pkg::CH_NUL) begin
					main_v      = 1'b1;
					main_r.kind = sap_pkg::K_DONE;
					phase_d     = PH_DONE;
				end else begin
					tag_d   = in_ch.in_byte;
					phase_d = PH_TAG1;
				end
			end
			PH_TAG1: begin
				if (code == sap_pkg::TAG_ARRAY) begin
					pairs_d  = '0;
					expect_d = 1'b0;
					phase_d  = PH_ADIG;
				end else if (code == sap_pkg::TAG_STRING) begin
					bytes_d = '0;
					phase_d = PH_SDIG;
				end else if (code == sap_pkg::TAG_DOUBLE || code == sap_pkg::TAG_INT) begin
					bytes_d = '0;
					phase_d = PH_NUM;
				end else if (code == sap_pkg::TAG_NULL && expect_q) begin
					main_v             = 1'b1;
					main_r.kind        = sap_pkg::K_VAL;
					main_r.field_end   = 1'b1;
					main_r.empty_field = 1'b1;
					finish             = 1'b1;
				end else begin
					main_v      = 1'b1;
					main_r.kind = sap_pkg::K_ERR;
					phase_d     = PH_DONE;
				end
			end
			PH_ADIG: begin
				if (digit) begin
					pairs_d = pairs_acc[COUNT_BITS-1:0];
					if (pairs_acc[COUNT_BITS+3:COUNT_BITS] != 4'd0) begin
						main_v      = 1'b1;
						main_r.kind = sap_pkg::K_ERR;
						phase_d     = PH_DONE;
					end
				end else begin
					seek_a = 1'b1;
				end
			end
			PH_ASEEK: seek_a = 1'b1;
			PH_SDIG: begin
				if (digit) begin
					bytes_d = bytes_acc[LEN_BITS-1:0];
					if (bytes_acc[LEN_BITS+3:LEN_BITS] != 4'd0) begin
						main_v      = 1'b1;
						main_r.kind = sap_pkg::K_ERR;
						phase_d     = PH_DONE;
					end
				end else begin
					seek_s = 1'b1;
				end
			end
			PH_SSEEK: seek_s = 1'b1;
			PH_SBODY: begin
				bytes_d          = bytes_dec;
				main_v           = 1'b1;
				main_r.kind      = kind_c;
				main_r.out_byte  = in_ch.in_byte;
				main_r.field_end = (bytes_dec == '0);
				if (bytes_dec == '0) begin
					skip_d = 2'd2;
					finish = 1'b1;
				end
			end
			PH_NUM: begin
				// hold the latest byte back so the last one can carry field_end
				if (in_ch.in_byte == sap_pkg::CH_SEMI) begin
					main_v           = 1'b1;
					main_r.kind      = kind_c;
					main_r.field_end = 1'b1;
					if (bytes_q != '0) begin
						main_r.out_byte = tag_q;
					end else begin
						main_r.empty_field = 1'b1;
					end
					bytes_d = '0;
					finish  = 1'b1;
				end else begin
					if (bytes_q != '0) begin
						main_v          = 1'b1;
						main_r.kind     = kind_c;
						main_r.out_byte = tag_q;
					end
					tag_d   = in_ch.in_byte;
					bytes_d = LEN_BITS'(1);
				end
			end
			default: phase_d = PH_DONE;
		endcase

		// look for the brace after the pair count
		if (seek_a) begin
			phase_d = PH_ASEEK;
			if (in_ch.in_byte == sap_pkg::CH_LBRACE) begin
				if (pairs_q == '0) begin
					skip_d = 2'd1;
				end
				phase_d = PH_TAG0;
			end
		end

		// look for the opening quote after the string length
		if (seek_s) begin
			phase_d = PH_SSEEK;
			if (in_ch.in_byte == sap_pkg::CH_QUOTE) begin
				if (bytes_q == '0) begin
					main_v             = 1'b1;
					main_r.kind        = kind_c;
					main_r.field_end   = 1'b1;
					main_r.empty_field = 1'b1;
					skip_d             = 2'd2;
					finish             = 1'b1;
				end else begin
					phase_d = PH_SBODY;
				end
			end
		end

		// close an element: flip key/value, count down pairs, skip the closing brace
		if (finish) begin
			expect_d = ~expect_q;
			if (pairs_q != '0 && expect_q) begin
				pairs_d = pairs_q - COUNT_BITS'(1);
				if (pairs_q == COUNT_BITS'(1) && skip_d != 2'd3) begin
					skip_d = skip_d + 2'd1;
				end
			end
			phase_d = PH_TAG0;
		end

		// end of buffer: report and start afresh
		if (in_ch.in_last) begin
			if (phase_d == PH_NUM) begin
				last_v      = 1'b1;
				last_r.kind = sap_pkg::K_ERR;
			end else if (phase_d != PH_DONE) begin
				last_v      = 1'b1;
				last_r.kind = sap_pkg::K_DONE;
			end
			phase_d  = PH_TAG0;
			tag_d    = 8'd0;
			pairs_d  = '0;
			expect_d = 1'b0;
			bytes_d  = '0;
			skip_d   = 2'd0;
		end
	end

	// pack up to two results in order
	assign res0   = main_v ? main_r : last_r;
	assign res1   = last_r;
	assign n_push = {1'b0, main_v} + {1'b0, last_v};

	// advance parser state on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG0;
			tag_q    <= 8'd0;
			pairs_q  <= '0;
			expect_q <= 1'b0;
			bytes_q  <= '0;
			skip_q   <= 2'd0;
		end else if (acc) begin
			phase_q  <= phase_d;
			tag_q    <= tag_d;
			pairs_q  <= pairs_d;
			expect_q <= expect_d;
			bytes_q  <= bytes_d;
			skip_q   <= skip_d;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (acc ? CNT_W'(n_push) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (acc && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (acc && n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	assign out_ch.valid       = count_q != '0;
	assign out_ch.kind        = fifo_q[rd_ptr_q].kind;
	assign out_ch.out_byte    = fifo_q[rd_ptr_q].out_byte;
	assign out_ch.field_end   = fifo_q[rd_ptr_q].field_end;
	assign out_ch.empty_field = fifo_q[rd_ptr_q].empty_field;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// bytes to drop are pending only at a tag position
	a_skip_phase: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q != 2'd0 |-> phase_q == PH_TAG0)
		else $error("skip count outside tag phase");

	// a held number byte is a flag, never a count
	a_num_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NUM |-> bytes_q <= LEN_BITS'(1))
		else $error("numeric hold flag out of range");

	// a finished parse stays silent until the end of its buffer
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_DONE && !in_ch.in_last |=> phase_q == PH_DONE &&
		count_q <= $past(count_q))
		else $error("result after parse end");

endmodule

`default_nettype wire

// ----- verif/tb_serialized_array_parser.sv -----
`timescale 1ns / 1ps

module tb_serialized_array_parser;

	localparam int LEN_BITS   = 20;
	localparam int COUNT_BITS = 16;
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] LEN_MAX   = (64'd1 << LEN_BITS) - 64'd1;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [3:0] {
		ST_TAG_LO,
		ST_TAG_HI,
		ST_COUNT_DIG,
		ST_COUNT_SEEK,
		ST_LEN_DIG,
		ST_LEN_SEEK,
		ST_STR_BODY,
		ST_NUMBER,
		ST_SPENT
	} parse_st_t;

	logic clk;
	logic arst_n;

	sap_in_if  in_ch ();
	sap_out_if out_ch ();

	serialized_array_parser #(
		.LEN_BITS  (LEN_BITS),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	// parser state as the block should hold it
	parse_st_t             parse_st;
	logic [7:0]            held_byte;
	logic [COUNT_BITS-1:0] pairs_left;
	logic                  want_value;
	logic                  saw_element;
	logic [LEN_BITS-1:0]   bytes_left;
	logic [1:0]            skip_left;

	sap_pkg::out_item_t parsed_items[$];

	int  items_sent;
	int  mismatch_count;
	int  cycle_count;
	int  hold_len;
	bit  idle_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic void parser_clear();
		parse_st    = ST_TAG_LO;
		held_byte   = '0;
		pairs_left  = '0;
		want_value  = 1'b0;
		saw_element = 1'b0;
		bytes_left  = '0;
		skip_left   = '0;
	endfunction

	function automatic void emit(input sap_pkg::kind_t k, input logic [7:0] b,
		input logic e, input logic m);
		parsed_items.push_back(sap_pkg::out_item_t'{k, b, e, m});
	endfunction

	function automatic void abort_parse();
		emit(sap_pkg::K_ERR, 8'h00, 1'b0, 1'b0);
		parse_st = ST_SPENT;
	endfunction

	// toggle key/value and count down pairs after each value
	function automatic void close_element();
		logic was_value;
		was_value   = want_value;
		want_value  = ~want_value;
		saw_element = 1'b1;
		if (pairs_left != 0 && saw_element && was_value) begin
			pairs_left--;
			if (pairs_left == 0 && skip_left < 2'd3)
				skip_left++;
		end
		parse_st = ST_TAG_LO;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		sap_pkg::kind_t field_kind;
		logic           is_digit;
		logic [15:0]    code;
		logic [63:0]    acc;
		field_kind = want_value ? sap_pkg::K_VAL : sap_pkg::K_KEY;
		is_digit   = (b >= sap_pkg::CH_ZERO) && (b <= sap_pkg::CH_NINE);

		// a non-digit ends a number and is then looked at by the seek state
		if (parse_st == ST_COUNT_DIG && !is_digit)
			parse_st = ST_COUNT_SEEK;
		if (parse_st == ST_LEN_DIG && !is_digit)
			parse_st = ST_LEN_SEEK;

		case (parse_st)
			ST_TAG_LO: begin
				if (skip_left != 0) begin
					skip_left--;
				end else if (b == sap_pkg::CH_NUL) begin
					emit(sap_pkg::K_DONE, 8'h00, 1'b0, 1'b0);
					parse_st = ST_SPENT;
				end else begin
					held_byte = b;
					parse_st  = ST_TAG_HI;
				end
			end
			ST_TAG_HI: begin
				code = {b, held_byte};
				if (code == sap_pkg::TAG_ARRAY) begin
					pairs_left  = '0;
					want_value  = 1'b0;
					saw_element = 1'b0;
					parse_st    = ST_COUNT_DIG;
				end else if (code == sap_pkg::TAG_STRING) begin
					bytes_left = '0;
					parse_st   = ST_LEN_DIG;
				end else if (code == sap_pkg::TAG_DOUBLE || code == sap_pkg::TAG_INT) begin
					bytes_left = '0;
					parse_st   = ST_NUMBER;
				end else if (code == sap_pkg::TAG_NULL && want_value) begin
					emit(sap_pkg::K_VAL, 8'h00, 1'b1, 1'b1);
					close_element();
				end else begin
					abort_parse();
				end
			end
			ST_COUNT_DIG: begin
				acc = 64'(pairs_left) * 64'd10 + 64'(b - sap_pkg::CH_ZERO);
				pairs_left = acc[COUNT_BITS-1:0];
				if (acc > COUNT_MAX)
					abort_parse();
			end
			ST_COUNT_SEEK: begin
				if (b == sap_pkg::CH_LBRACE) begin
					if (pairs_left == 0)
						skip_left = 2'd1;
					parse_st = ST_TAG_LO;
				end
			end
			ST_LEN_DIG: begin
				acc = 64'(bytes_left) * 64'd10 + 64'(b - sap_pkg::CH_ZERO);
				bytes_left = acc[LEN_BITS-1:0];
				if (acc > LEN_MAX)
					abort_parse();
			end
			ST_LEN_SEEK: begin
				if (b == sap_pkg::CH_QUOTE) begin
					if (bytes_left == 0) begin
						emit(field_kind, 8'h00, 1'b1, 1'b1);
						skip_left = 2'd2;
						close_element();
					end else begin
						parse_st = ST_STR_BODY;
					end
				end
			end
			ST_STR_BODY: begin
				bytes_left--;
				emit(field_kind, b, bytes_left == 0, 1'b0);
				if (bytes_left == 0) begin
					skip_left = 2'd2;
					close_element();
				end
			end
			ST_NUMBER: begin
				if (b == sap_pkg::CH_SEMI) begin
					if (bytes_left != 0)
						emit(field_kind, held_byte, 1'b1, 1'b0);
					else
						emit(field_kind, 8'h00, 1'b1, 1'b1);
					bytes_left = '0;
					close_element();
				end else begin
					// hold the byte back so the next one can tell if it was the last
					if (bytes_left != 0)
						emit(field_kind, held_byte, 1'b0, 1'b0);
					held_byte  = b;
					bytes_left = 1;
				end
			end
			default: parse_st = ST_SPENT;
		endcase

		// close the buffer
		if (last) begin
			if (parse_st == ST_NUMBER)
				emit(sap_pkg::K_ERR, 8'h00, 1'b0, 1'b0);
			else if (parse_st != ST_SPENT)
				emit(sap_pkg::K_DONE, 8'h00, 1'b0, 1'b0);
			parser_clear();
		end
	endfunction

	// ---------------------------------------------------------------
	// Text builders
	// ---------------------------------------------------------------

	function automatic void put_str(ref logic [7:0] text[$], input string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	function automatic void add_element(ref logic [7:0] text[$], input bit as_key);
		int sel;
		int n;
		logic [7:0] b;
		sel = as_key ? $urandom_range(0, 2) : $urandom_range(0, 3);
		case (sel)
			0: begin
				n = $urandom_range(0, 4);
				put_str(text, $sformatf("s:%0d:\"", n));
				repeat (n) text.push_back(8'($urandom_range(0, 255)));
				put_str(text, "\";");
			end
			1, 2: begin
				put_str(text, (sel == 1) ? "i:" : "d:");
				n = $urandom_range(0, 3);
				repeat (n) begin
					b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
						: 8'(sap_pkg::CH_ZERO + $urandom_range(0, 9));
					if (b == sap_pkg::CH_SEMI)
						b = sap_pkg::CH_NINE;
					text.push_back(b);
				end
				text.push_back(sap_pkg::CH_SEMI);
			end
			default: put_str(text, "N;");
		endcase
	endfunction

	// mostly well-formed arrays or bare key/value pairs, the rest truncated, corrupted, at the limits or noise
	function automatic void build_document(ref logic [7:0] text[$]);
		int mode;
		int n;
		int cut;
		text.delete();
		mode = $urandom_range(0, 9);
		if (mode <= 7) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					add_element(text, 1'b1);
					add_element(text, 1'b0);
				end
			end else begin
				n = $urandom_range(0, 3);
				put_str(text, $sformatf("a:%0d", n));
				if ($urandom_range(0, 4) == 0)
					text.push_back(8'($urandom_range(0, 255)));
				put_str(text, ":{");
				repeat (n) begin
					add_element(text, 1'b1);
					add_element(text, 1'b0);
				end
				put_str(text, "}");
			end
			if ($urandom_range(0, 4) == 0) begin
				text.push_back(sap_pkg::CH_NUL);
				repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
			end
			if (mode == 6) begin
				cut = $urandom_range(1, text.size());
				while (text.size() > cut)
					void'(text.pop_back());
			end
			if (mode == 7)
				text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (mode == 8) begin
			case ($urandom_range(0, 3))
				0: put_str(text, $sformatf("a:%0d:{", COUNT_MAX + 1));
				1: put_str(text, $sformatf("s:%0d:\"ab", LEN_MAX + 1));
				2: put_str(text, $sformatf("a:%0d:{i:1;N;s:0:\"\";", COUNT_MAX));
				default: put_str(text, $sformatf("s:%0d:\"xy", LEN_MAX));
			endcase
		end else begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------

	task automatic send_byte(input logic [7:0] b, input logic last);
		// insert a random idle burst before the request
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		parse_byte(b, last);
		items_sent++;
	endtask

	task automatic send_text(ref logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic wait_all_results();
		in_ch.valid <= 1'b0;
		while (parsed_items.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Receiver
	// ---------------------------------------------------------------

	initial begin
		int n;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len != 0) begin
				// long hold-off so the result queue fills and the input stalls
				n        = hold_len;
				hold_len = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		sap_pkg::out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (parsed_items.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 30)
					$display("%0t: unexpected result, expected none,", $time,
						" got kind %0d byte %02h end %0b empty %0b",
						out_ch.kind, out_ch.out_byte, out_ch.field_end,
						out_ch.empty_field);
			end else begin
				want = parsed_items.pop_front();
				if (out_ch.kind !== want.kind || out_ch.out_byte !== want.out_byte
					|| out_ch.field_end !== want.field_end
					|| out_ch.empty_field !== want.empty_field) begin
					mismatch_count++;
					if (mismatch_count <= 30)
						$display("%0t: mismatch,", $time,
							" expected kind %0d byte %02h end %0b empty %0b,",
							want.kind, want.out_byte, want.field_end,
							want.empty_field,
							" got kind %0d byte %02h end %0b empty %0b",
							out_ch.kind, out_ch.out_byte,
							out_ch.field_end, out_ch.empty_field);
				end
			end
		end
	end

	// end the run on a hang
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_directed();
		logic [7:0] text[$];
		// empty array with its closing brace
		put_str(text, "a:0:{}");
		send_text(text);
		// null in key position
		text.delete();
		put_str(text, "N;");
		send_text(text);
		// unknown tag built from the extreme byte values
		text = '{8'hff, 8'h00};
		send_text(text);
		// empty numeric key, null value, completion on NUL
		text.delete();
		put_str(text, "i:;N;");
		text.push_back(sap_pkg::CH_NUL);
		send_text(text);
		// string key with extreme content, then a number cut off by the buffer end
		text.delete();
		put_str(text, "s:2:\"");
		text.push_back(8'h00);
		text.push_back(8'hff);
		put_str(text, "\";i:7");
		send_text(text);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [7:0] text[$];
		int start;
		start = items_sent;
		while (items_sent - start < n_items) begin
			build_document(text);
			send_text(text);
		end
	endtask

	task automatic test_output_hold();
		hold_len = 300;
		test_random_traffic(60);
	endtask

	task automatic test_drain_pause();
		wait_all_results();
		test_random_traffic(40);
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		test_random_traffic(120);
	endtask

	initial begin
		items_sent     = 0;
		mismatch_count = 0;
		hold_len       = 0;
		idle_on        = 1'b1;
		parser_clear();
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.in_byte <= 8'h00;
		in_ch.in_last <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(300);
		test_output_hold();
		test_drain_pause();
		test_steady_stream();

		wait_all_results();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/sap_pkg.sv
sv/sap_in_if.sv
sv/sap_out_if.sv
sv/serialized_array_parser.sv
verif/tb_serialized_array_parser.sv
